// ===== rtl/core/rmdq_pkg.sv =====
// Shared types and constants for the rigid-motion to dual-quaternion converter.
package rmdq_pkg;

  localparam int ROT_FRAC_BITS_DEF = 14;
  localparam int ROOT_STEPS        = 4;   // square-root bits resolved per stage
  localparam int PROD_W            = 48;  // 32 x 16 signed product
  localparam int SUM_W             = 50;  // sum of three products, negated if needed

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tz;
  } pose_t;

  typedef struct packed {
    logic signed [15:0] q_w;
    logic signed [15:0] q_x;
    logic signed [15:0] q_y;
    logic signed [15:0] q_z;
    logic signed [31:0] dual_w;
    logic signed [31:0] dual_x;
    logic signed [31:0] dual_y;
    logic signed [31:0] dual_z;
  } dq_t;

  // sign flags and translation riding alongside the root pipeline
  typedef struct packed {
    logic [2:0]         neg;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tz;
  } side_t;

  typedef struct packed {
    logic signed [15:0] q_w;
    logic signed [15:0] q_x;
    logic signed [15:0] q_y;
    logic signed [15:0] q_z;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tz;
  } quat_t;

endpackage

// ===== rtl/core/rigid_motion_to_dual_quaternion.sv =====
// Rigid pose (rotation matrix and translation) to dual quaternion converter, top level.
// Takes one pose per clock unless stalled and returns one dual quaternion per pose, in
// order. A front register holds the four clamped diagonal sums, the shared-shape
// square-root pipeline resolves up to four bits of the SW-bit root (16 at 14 rotation
// fraction bits) per stage in all four lanes at once, a register saturates and signs the
// quaternion, and the dual stages form the translation products, their sums and the
// rounded, saturated dual part. All stages advance unless a finished word waits under stall.
module rigid_motion_to_dual_quaternion #(
  parameter int ROT_FRAC_BITS = rmdq_pkg::ROT_FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            pose_valid,
  output logic            pose_stall,
  input  rmdq_pkg::pose_t pose,
  output logic            dq_valid,
  input  logic            dq_stall,
  output rmdq_pkg::dq_t   dq
);

  localparam int R     = ROT_FRAC_BITS;
  localparam int CMAG  = ((R > 17) ? R : 17) + 2;
  localparam int CW    = CMAG + 1;
  localparam int VRAW  = CMAG + R - 2;
  localparam int SW    = (VRAW + 1) / 2;
  localparam int VW    = 2 * SW;
  localparam int STEPS = rmdq_pkg::ROOT_STEPS;
  localparam int NST   = (SW + STEPS - 1) / STEPS;
  localparam int D     = NST + 5;
  localparam int QW    = (SW > 16) ? SW : 16;

  logic         adv;
  logic [D-1:0] vld;

  assign adv        = !(vld[D-1] && dq_stall);
  assign pose_stall = !adv;
  assign dq_valid   = vld[D-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[D-2:0], pose_valid};
    end
  end

  // front stage: diagonal combinations, clamp, sign flags
  logic [3:0][VW-1:0] rad_s  [0:NST];
  logic [3:0][SW+1:0] rem_s  [0:NST];
  logic [3:0][SW-1:0] root_s [0:NST];
  rmdq_pkg::side_t    side   [0:NST];

  logic [3:0][VW-1:0] rad_next;
  rmdq_pkg::side_t    side_next;

  always_comb begin
    logic signed [CW-1:0] one, a, b, c;
    logic signed [CW-1:0] comb [0:3];
    logic signed [16:0]   dx, dy, dz;
    one = CW'(1) <<< R;
    a   = CW'(pose.m00);
    b   = CW'(pose.m11);
    c   = CW'(pose.m22);
    comb[0] = one + a + b + c;
    comb[1] = one + a - b - c;
    comb[2] = one - a + b - c;
    comb[3] = one - a - b + c;
    for (int l = 0; l < 4; l++) begin
      rad_next[l] = comb[l][CW-1] ? '0 : (VW'(comb[l][CMAG-1:0]) << (R - 2));
    end
    dx = 17'(pose.m21) - 17'(pose.m12);
    dy = 17'(pose.m02) - 17'(pose.m20);
    dz = 17'(pose.m10) - 17'(pose.m01);
    side_next.neg = {dz[16], dy[16], dx[16]};
    side_next.tx  = pose.tx;
    side_next.ty  = pose.ty;
    side_next.tz  = pose.tz;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rad_s[0] <= rad_next;
      side[0]  <= side_next;
    end
  end

  assign rem_s[0]  = '0;
  assign root_s[0] = '0;

  for (genvar k = 0; k < NST; k++) begin : g_root
    localparam int NS = ((SW - k * STEPS) < STEPS) ? (SW - k * STEPS) : STEPS;
    rmdq_root_stage #(
      .SW     (SW),
      .NSTEPS (NS)
    ) u_stage (
      .clk    (clk),
      .en     (adv),
      .rad_d  (rad_s[k]),
      .rem_d  (rem_s[k]),
      .root_d (root_s[k]),
      .rad_q  (rad_s[k+1]),
      .rem_q  (rem_s[k+1]),
      .root_q (root_s[k+1])
    );

    always_ff @(posedge clk) begin
      if (adv) begin
        side[k+1] <= side[k];
      end
    end
  end

  // saturate magnitudes and apply signs
  rmdq_pkg::quat_t quat, quat_next;

  always_comb begin
    logic [15:0] mag [0:3];
    for (int l = 0; l < 4; l++) begin
      if (QW'(root_s[NST][l]) > QW'(16'h7FFF)) begin
        mag[l] = 16'h7FFF;
      end else begin
        mag[l] = 16'(root_s[NST][l]);
      end
    end
    quat_next.q_w = mag[0];
    quat_next.q_x = side[NST].neg[0] ? -mag[1] : mag[1];
    quat_next.q_y = side[NST].neg[1] ? -mag[2] : mag[2];
    quat_next.q_z = side[NST].neg[2] ? -mag[3] : mag[3];
    quat_next.tx  = side[NST].tx;
    quat_next.ty  = side[NST].ty;
    quat_next.tz  = side[NST].tz;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      quat <= quat_next;
    end
  end

  rmdq_dual #(
    .ROT_FRAC_BITS (ROT_FRAC_BITS)
  ) u_dual (
    .clk (clk),
    .en  (adv),
    .q   (quat),
    .dq  (dq)
  );

  a_w_nonneg: assert property (@(posedge clk) disable iff (rst)
    dq_valid |-> !dq.q_w[15])
    else $error("scalar part negative");

  a_vec_range: assert property (@(posedge clk) disable iff (rst)
    dq_valid |-> (dq.q_x != 16'sh8000) && (dq.q_y != 16'sh8000) && (dq.q_z != 16'sh8000))
    else $error("vector part beyond saturated magnitude");

  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !dq_valid)
    else $error("result word after reset");

endmodule

// ===== rtl/core/rmdq_root_stage.sv =====
// One pipeline stage of the four-lane digit-by-digit integer square root.
module rmdq_root_stage #(
  parameter int SW     = 16,
  parameter int NSTEPS = 4
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [3:0][2*SW-1:0]        rad_d,
  input  logic [3:0][SW+1:0]          rem_d,
  input  logic [3:0][SW-1:0]          root_d,
  output logic [3:0][2*SW-1:0]        rad_q,
  output logic [3:0][SW+1:0]          rem_q,
  output logic [3:0][SW-1:0]          root_q
);

  localparam int VW = 2 * SW;

  logic [3:0][VW-1:0] rad_next;
  logic [3:0][SW+1:0] rem_next;
  logic [3:0][SW-1:0] root_next;

  always_comb begin
    logic [VW-1:0] r;
    logic [SW+1:0] rm;
    logic [SW-1:0] rt;
    logic [SW+2:0] acc;
    logic [SW+1:0] tr;
    for (int l = 0; l < 4; l++) begin
      r  = rad_d[l];
      rm = rem_d[l];
      rt = root_d[l];
      for (int s = 0; s < NSTEPS; s++) begin
        // bring down the next two radicand bits, try root*4+1
        acc = {rm[SW:0], r[VW-1 -: 2]};
        tr  = {rt, 2'b01};
        if (acc >= {1'b0, tr}) begin
          rm = (SW+2)'(acc - {1'b0, tr});
          rt = {rt[SW-2:0], 1'b1};
        end else begin
          rm = (SW+2)'(acc);
          rt = {rt[SW-2:0], 1'b0};
        end
        r = r << 2;
      end
      rad_next[l]  = r;
      rem_next[l]  = rm;
      root_next[l] = rt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_q  <= rad_next;
      rem_q  <= rem_next;
      root_q <= root_next;
    end
  end

endmodule

// ===== rtl/core/rmdq_dual.sv =====
// Dual part: products, sums, then round and saturate, three register stages.
module rmdq_dual #(
  parameter int ROT_FRAC_BITS = rmdq_pkg::ROT_FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            en,
  input  rmdq_pkg::quat_t q,
  output rmdq_pkg::dq_t   dq
);

  localparam int PW   = rmdq_pkg::PROD_W;
  localparam int SUMW = rmdq_pkg::SUM_W;
  localparam logic signed [SUMW:0] SAT_MAX = (SUMW+1)'(33'sh0_7FFF_FFFF);
  localparam logic signed [SUMW:0] SAT_MIN = (SUMW+1)'(33'sh1_8000_0000);

  logic signed [PW-1:0]   p [0:11];
  logic signed [SUMW-1:0] s [0:3];
  logic signed [15:0]     q1 [0:3];
  logic signed [15:0]     q2 [0:3];
  logic signed [31:0]     d_next [0:3];

  always_ff @(posedge clk) begin
    if (en) begin
      p[0]  <= q.tx * q.q_x;
      p[1]  <= q.ty * q.q_y;
      p[2]  <= q.tz * q.q_z;
      p[3]  <= q.tx * q.q_w;
      p[4]  <= q.ty * q.q_z;
      p[5]  <= q.tz * q.q_y;
      p[6]  <= q.tx * q.q_z;
      p[7]  <= q.ty * q.q_w;
      p[8]  <= q.tz * q.q_x;
      p[9]  <= q.tx * q.q_y;
      p[10] <= q.ty * q.q_x;
      p[11] <= q.tz * q.q_w;
      q1[0] <= q.q_w;
      q1[1] <= q.q_x;
      q1[2] <= q.q_y;
      q1[3] <= q.q_z;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s[0] <= -(SUMW'(p[0]) + SUMW'(p[1]) + SUMW'(p[2]));
      s[1] <= SUMW'(p[3]) + SUMW'(p[4]) - SUMW'(p[5]);
      s[2] <= -SUMW'(p[6]) + SUMW'(p[7]) + SUMW'(p[8]);
      s[3] <= SUMW'(p[9]) - SUMW'(p[10]) + SUMW'(p[11]);
      q2   <= q1;
    end
  end

  // halve and drop the rotation fraction: round to nearest, ties up
  always_comb begin
    logic signed [SUMW:0] r;
    for (int i = 0; i < 4; i++) begin
      r = ((SUMW+1)'(s[i]) + ((SUMW+1)'(1) <<< ROT_FRAC_BITS)) >>> (ROT_FRAC_BITS + 1);
      if (r > SAT_MAX) begin
        d_next[i] = 32'sh7FFF_FFFF;
      end else if (r < SAT_MIN) begin
        d_next[i] = 32'sh8000_0000;
      end else begin
        d_next[i] = 32'(r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dq.q_w    <= q2[0];
      dq.q_x    <= q2[1];
      dq.q_y    <= q2[2];
      dq.q_z    <= q2[3];
      dq.dual_w <= d_next[0];
      dq.dual_x <= d_next[1];
      dq.dual_y <= d_next[2];
      dq.dual_z <= d_next[3];
    end
  end

endmodule

// ===== dv/tb_rigid_motion_to_dual_quaternion.sv =====
// Testbench for the rigid-motion to dual-quaternion converter.
module tb_rigid_motion_to_dual_quaternion;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROT_FB = 14;
  localparam int LATENCY = 9;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pose_valid = 1'b0;
  logic pose_stall;
  rmdq_pkg::pose_t pose = '0;
  logic dq_valid;
  logic dq_stall = 1'b0;
  rmdq_pkg::dq_t dq;

  rmdq_pkg::dq_t expected_dq[$];
  int mismatches = 0;
  int words_checked = 0;
  int poses_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;
  longint cycles = 0;

  rigid_motion_to_dual_quaternion DUT (
    .clk(clk), .rst(rst),
    .pose_valid(pose_valid), .pose_stall(pose_stall), .pose(pose),
    .dq_valid(dq_valid), .dq_stall(dq_stall), .dq(dq)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_rigid_motion_to_dual_quaternion failed");
      $finish;
    end
  end

  // exact integer square root
  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint half_mag(longint c);
    longint unsigned r;
    if (c < 0) c = 0;
    r = int_root((longint'(c) << ROT_FB) >> 2);
    if (r > 32767) r = 32767;
    return longint'(r);
  endfunction

  function automatic logic signed [31:0] round_sat(longint v);
    longint s;
    s = (v + (longint'(1) << ROT_FB)) >>> (ROT_FB + 1);
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s[31:0];
  endfunction

  function automatic rmdq_pkg::dq_t dual_quat_of(rmdq_pkg::pose_t p);
    longint a00, a01, a02, a10, a11, a12, a20, a21, a22, x, y, z, one, w, i, j, k;
    rmdq_pkg::dq_t r;
    a00 = p.m00; a01 = p.m01; a02 = p.m02;
    a10 = p.m10; a11 = p.m11; a12 = p.m12;
    a20 = p.m20; a21 = p.m21; a22 = p.m22;
    x = p.tx; y = p.ty; z = p.tz;
    one = longint'(1) << ROT_FB;
    w = half_mag(one + a00 + a11 + a22);
    i = half_mag(one + a00 - a11 - a22);
    j = half_mag(one - a00 + a11 - a22);
    k = half_mag(one - a00 - a11 + a22);
    if (a21 - a12 < 0) i = -i;
    if (a02 - a20 < 0) j = -j;
    if (a10 - a01 < 0) k = -k;
    r.q_w = w[15:0]; r.q_x = i[15:0]; r.q_y = j[15:0]; r.q_z = k[15:0];
    r.dual_w = round_sat(-(x * i + y * j + z * k));
    r.dual_x = round_sat(x * w + y * k - z * j);
    r.dual_y = round_sat(-x * k + y * w + z * i);
    r.dual_z = round_sat(x * j - y * i + z * w);
    return r;
  endfunction

  task automatic send_pose(rmdq_pkg::pose_t p);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      pose_valid <= 1'b0;
      @(posedge clk);
    end
    pose_valid <= 1'b1;
    pose <= p;
    expected_dq.push_back(dual_quat_of(p));
    @(posedge clk);
    while (pose_stall) @(posedge clk);
    poses_sent++;
  endtask

  task automatic idle_sender();
    pose_valid <= 1'b0;
  endtask

  // receiver stall; hold-off overrides
  always @(posedge clk) begin
    if (rst) dq_stall <= 1'b0;
    else dq_stall <= hold_off || (recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    rmdq_pkg::dq_t want;
    if (!rst && dq_valid && !dq_stall) begin
      if (expected_dq.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", dq);
      end else begin
        want = expected_dq.pop_front();
        words_checked++;
        if (want !== dq) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp q=%0d %0d %0d %0d d=%0d %0d %0d %0d",
                     want.q_w, want.q_x, want.q_y, want.q_z,
                     want.dual_w, want.dual_x, want.dual_y, want.dual_z);
            $display("          got q=%0d %0d %0d %0d d=%0d %0d %0d %0d",
                     dq.q_w, dq.q_x, dq.q_y, dq.q_z,
                     dq.dual_w, dq.dual_x, dq.dual_y, dq.dual_z);
          end
        end
      end
    end
  end

  function automatic rmdq_pkg::pose_t mk_pose(int d0, int d1, int d2, int o01, int o02,
                                              int o10, int o12, int o20, int o21,
                                              int x, int y, int z);
    rmdq_pkg::pose_t p;
    p.m00 = 16'(d0); p.m11 = 16'(d1); p.m22 = 16'(d2);
    p.m01 = 16'(o01); p.m02 = 16'(o02); p.m10 = 16'(o10);
    p.m12 = 16'(o12); p.m20 = 16'(o20); p.m21 = 16'(o21);
    p.tx = x; p.ty = y; p.tz = z;
    return p;
  endfunction

  function automatic rmdq_pkg::pose_t random_pose();
    rmdq_pkg::pose_t p;
    p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         16'($urandom)};
    case ($urandom_range(3))
      0: ; // raw bit patterns
      1: begin // near-rotation entries, moderate x and y translation
        p.m00 = $signed(16'($urandom_range(32768))) - 16'sd16384;
        p.m11 = $signed(16'($urandom_range(32768))) - 16'sd16384;
        p.m22 = $signed(16'($urandom_range(32768))) - 16'sd16384;
        p.m01 = $signed(16'($urandom_range(32768))) - 16'sd16384;
        p.m12 = $signed(16'($urandom_range(32768))) - 16'sd16384;
        p.m20 = $signed(16'($urandom_range(32768))) - 16'sd16384;
        p.tx = $signed(p.tx) >>> $urandom_range(31);
        p.ty = $signed(p.ty) >>> $urandom_range(31);
      end
      2: begin // equal off-diagonals give zero differences
        p.m21 = p.m12; p.m02 = p.m20;
        if ($urandom_range(1)) p.m10 = p.m01;
      end
      default: begin // large translations push the dual part into saturation
        p.tx = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
        p.m00 = 16'sh7fff; p.m11 = 16'sh7fff; p.m22 = 16'sh7fff;
      end
    endcase
    return p;
  endfunction

  task automatic wait_drained();
    idle_sender();
    while (expected_dq.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic test_directed();
    send_pose(mk_pose(16384, 16384, 16384, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_pose(mk_pose(16384, 16384, 16384, 0, 0, 0, 0, 0, 0, 65536, -65536, 131072));
    send_pose(mk_pose(16384, -16384, -16384, 0, 0, 0, 0, 0, 0, 1, 2, 3));
    send_pose(mk_pose(-16384, 16384, -16384, 0, 0, 0, 0, 0, 0, -1, -2, -3));
    send_pose(mk_pose(-16384, -16384, 16384, 0, 0, 0, 0, 0, 0, 100, 200, 300));
    send_pose(mk_pose(0, 0, 0, 16384, -16384, -16384, 16384, 16384, -16384, 7, 8, 9));
    send_pose(mk_pose(0, 0, 0, -16384, 16384, 16384, -16384, -16384, 16384, 7, 8, 9));
    send_pose(mk_pose(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                      32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    send_pose(mk_pose(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                      -32768, 32'h80000000, 32'h80000000, 32'h80000000));
    send_pose(mk_pose(32767, 32767, 32767, -32768, 32767, 32767, -32768, -32768, 32767,
                      32'h80000000, 32'h7fffffff, 32'h80000000));
    send_pose(mk_pose(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767, -32768,
                      32'h7fffffff, 32'h80000000, 32'h7fffffff));
    send_pose(mk_pose(-32768, 32767, -32768, 0, 0, 0, 0, 0, 0, -1, -1, -1));
    send_pose(mk_pose(5, 5, 5, 3, 3, 3, 3, 3, 3, 1, 1, 1));
    send_pose(mk_pose(-1, -1, -1, -1, -1, -1, -1, -1, -1, 32768, 32768, 32768));
    wait_drained();
  endtask

  task automatic test_random(int n, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) send_pose(random_pose());
    wait_drained();
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  // hold the receiver off while the sender keeps offering words
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (60) @(posedge clk);
        hold_off = 1'b0;
      end
      repeat (40) send_pose(random_pose());
    join
    wait_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(100, 0, 0);
    test_random(80, 65, 0);
    test_random(80, 0, 65);
    test_random(80, 29, 29);
    test_random(50, 0, 0);
    test_backpressure();
    $display("covered %0d poses: extremes, sign cases, zero differences, saturation,",
             poses_sent);
    $display("random idling and stalls and a long hold-off; %0d words checked",
             words_checked);
    if (mismatches == 0 && expected_dq.size() == 0) begin
      $display("tb_rigid_motion_to_dual_quaternion passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb_rigid_motion_to_dual_quaternion failed");
    end
    $finish;
  end
endmodule
